[hw/rtl/great_circle_distance_core_macros.svh]
`ifndef GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_MACROS_SVH

// Checks a property on the rising edge of clk, ignored while reset is low.
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a signal keeps its value in the cycle after a condition.
`define GCD_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[hw/rtl/gcd_pkg.sv]
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int SQRT_STEPS   = 31;
  localparam int STEP_W       = 6;
  localparam int ROOT_W       = 5;

  localparam logic signed [25:0] DEG_FULL    = 26'sd23592960;
  localparam logic signed [25:0] DEG_HALF    = 26'sd11796480;
  localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;
  localparam logic signed [48:0] RAD_PER_DEG = 49'sd18740330;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [34:0] HALF_PI_Q30  = 35'sd1686629713;
  localparam logic signed [34:0] ONE_Q30      = 35'sd1073741824;
  localparam logic [21:0] RADIUS_RESET = 22'd1630979;
  localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;

  typedef struct packed {
    logic signed [23:0] r;
    logic               neg;
  } fold_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } rot_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } vec_t;

  typedef struct packed {
    logic [60:0]        v;
    logic [61:0]        res;
    logic signed [31:0] t;
  } root_t;

  function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [29:0] a;
    case (i)
      6'd0:    a = 30'd843314856;
      6'd1:    a = 30'd497837829;
      6'd2:    a = 30'd263043836;
      6'd3:    a = 30'd133525158;
      6'd4:    a = 30'd67021686;
      6'd5:    a = 30'd33543515;
      6'd6:    a = 30'd16775850;
      6'd7:    a = 30'd8388437;
      6'd8:    a = 30'd4194282;
      6'd9:    a = 30'd2097149;
      6'd10:   a = 30'd1048575;
      6'd11:   a = 30'd524287;
      6'd12:   a = 30'd262143;
      6'd13:   a = 30'd131071;
      6'd14:   a = 30'd65535;
      6'd15:   a = 30'd32767;
      6'd16:   a = 30'd16383;
      6'd17:   a = 30'd8191;
      6'd18:   a = 30'd4095;
      6'd19:   a = 30'd2047;
      6'd20:   a = 30'd1023;
      6'd21:   a = 30'd511;
      6'd22:   a = 30'd255;
      6'd23:   a = 30'd127;
      6'd24:   a = 30'd63;
      6'd25:   a = 30'd31;
      6'd26:   a = 30'd15;
      6'd27:   a = 30'd7;
      6'd28:   a = 30'd3;
      6'd29:   a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // Reduces an angle to [-180, 180) degrees and then folds it into [-90, 90],
  // flagging the half turn so that sine and cosine can be negated afterwards.
  function automatic fold_t fold_deg(input logic signed [25:0] v);
    logic signed [25:0] m;
    logic signed [25:0] f;
    fold_t              o;
    m = v;
    if (v >= DEG_HALF) begin
      m = v - DEG_FULL;
    end else if (v < -DEG_HALF) begin
      m = v + DEG_FULL;
    end
    o.neg = 1'b0;
    f = m;
    if (m > DEG_QUARTER) begin
      f = m - DEG_HALF;
      o.neg = 1'b1;
    end else if (m < -DEG_QUARTER) begin
      f = m + DEG_HALF;
      o.neg = 1'b1;
    end
    o.r = f[23:0];
    return o;
  endfunction

endpackage

[hw/rtl/gcd_rot_cell.sv]
`timescale 1ns / 1ps

module gcd_rot_cell import gcd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] idx,
  input  rot_t              d_in,
  output rot_t              d_out
);

  rot_t               d_nxt;
  rot_t               d_r;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;

  always_comb begin
    dx = d_in.y >>> idx;
    dy = d_in.x >>> idx;
    at = $signed({4'b0, atan_q30(idx)});
    d_nxt = d_in;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

[hw/rtl/gcd_root_cell.sv]
`timescale 1ns / 1ps

module gcd_root_cell import gcd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] idx,
  input  root_t             d_in,
  output root_t             d_out
);

  root_t       d_nxt;
  root_t       d_r;
  logic [61:0] bit_v;
  logic [61:0] trial;

  // One result bit per cell; idx selects the power of four being tried.
  always_comb begin
    bit_v = 62'd1 << {idx, 1'b0};
    trial = d_in.res + bit_v;
    d_nxt = d_in;
    if ({1'b0, d_in.v} >= trial) begin
      d_nxt.v   = d_in.v - trial[60:0];
      d_nxt.res = (d_in.res >> 1) + bit_v;
    end else begin
      d_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

[hw/rtl/gcd_vec_cell.sv]
`timescale 1ns / 1ps

module gcd_vec_cell import gcd_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [STEP_W-1:0] idx,
  input  vec_t              d_in,
  output vec_t              d_out
);

  vec_t               d_nxt;
  vec_t               d_r;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;

  always_comb begin
    dx = d_in.y >>> idx;
    dy = d_in.x >>> idx;
    at = $signed({4'b0, atan_q30(idx)});
    if (d_in.y > 0) begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end else begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

[hw/rtl/great_circle_distance_core.sv]
`timescale 1ns / 1ps

// Great-circle distance core. Each request carries two points as latitude and
// longitude in degrees (signed, 16 fraction bits); the result is the distance
// in 1/256 km by the spherical law of cosines, rounded and saturated at 24
// bits, for a sphere whose radius is set through cfg_we/cfg_wdata (1/256 km,
// Earth by default). The core is a fully pipelined chain of CORDIC rotation
// cells, square root digit cells and CORDIC vectoring cells, so it takes one
// request per cycle and returns results in order. When a result is waiting and
// out_ready is low the whole pipeline holds and in_ready drops with it. The
// radius is read at the end of the pipeline, so it should be written only while
// no request is in flight.

`include "great_circle_distance_core_macros.svh"

module great_circle_distance_core import gcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_start_latitude,
  input  logic signed [24:0] in_start_longitude,
  input  logic signed [23:0] in_end_latitude,
  input  logic signed [24:0] in_end_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_distance,
  input  logic               cfg_we,
  input  logic [21:0]        cfg_wdata
);

  localparam int VP4 = 7 + CORDIC_STEPS;
  localparam int VSQ = 9 + CORDIC_STEPS + SQRT_STEPS;
  localparam int VF  = 41 + 2 * CORDIC_STEPS;
  localparam int LAT = 44 + 2 * CORDIC_STEPS;

  logic               adv;
  logic [LAT-1:0]     vld_r;
  logic [LAT-1:0]     vld_nxt;
  logic [21:0]        radius_r;

  logic signed [25:0] lat_a_r [3];
  fold_t              fold_nxt [3];
  fold_t              fold_r [3];
  logic signed [48:0] prod_r [3];
  logic               neg_c_r [3];
  rot_t               rot_c [CORDIC_STEPS+1][3];

  logic signed [31:0] sn_r [3];
  logic signed [31:0] cs_r [3];
  logic signed [63:0] pss_r;
  logic signed [63:0] pcc_r;
  logic signed [31:0] cd1_r;
  logic signed [63:0] ssr;
  logic signed [63:0] ccr;
  logic signed [31:0] a2_r;
  logic signed [31:0] cc2_r;
  logic signed [31:0] cd2_r;
  logic signed [63:0] m_r;
  logic signed [31:0] a3_r;
  logic signed [63:0] mr;
  logic signed [34:0] t_sum;
  logic signed [31:0] t_r;
  logic [60:0]        tt_r;
  logic signed [31:0] t_q_r;
  logic signed [63:0] tt_full;
  root_t              root_q_r;
  root_t              root_c [SQRT_STEPS+1];
  vec_t               vec_c [CORDIC_STEPS+1];
  logic signed [34:0] theta_s;
  logic [31:0]        theta_r;
  logic [53:0]        rprod_r;
  logic [54:0]        dist_sum;
  logic [23:0]        dist_r;

  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= RADIUS_RESET;
    end else begin
      if (adv) begin
        vld_r <= vld_nxt;
      end
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
    end
  end

  // Front end: longitude difference, range reduction and conversion to radians.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fold_nxt[j] = fold_deg(lat_a_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat_a_r[0] <= 26'(in_start_latitude);
      lat_a_r[1] <= 26'(in_end_latitude);
      lat_a_r[2] <= 26'(in_start_longitude) - 26'(in_end_longitude);
      for (int j = 0; j < 3; j++) begin
        fold_r[j]  <= fold_nxt[j];
        prod_r[j]  <= 49'(fold_r[j].r) * RAD_PER_DEG;
        neg_c_r[j] <= fold_r[j].neg;
      end
    end
  end

  genvar gi, gj;
  generate
    for (gj = 0; gj < 3; gj++) begin : g_rot_in
      logic signed [48:0] zs;
      assign zs = (prod_r[gj] + 49'sd32768) >>> 16;
      assign rot_c[0][gj].x   = CORDIC_START;
      assign rot_c[0][gj].y   = '0;
      assign rot_c[0][gj].z   = zs[33:0];
      assign rot_c[0][gj].neg = neg_c_r[gj];
    end
    for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_rot
      for (gj = 0; gj < 3; gj++) begin : g_ch
        gcd_rot_cell u_cell (
          .clk   (clk),
          .en    (adv),
          .idx   (STEP_W'(gi)),
          .d_in  (rot_c[gi][gj]),
          .d_out (rot_c[gi+1][gj])
        );
      end
    end
  endgenerate

  // Cosine argument: sin a1 sin a2 + cos a1 cos a2 cos(o1 - o2), clamped.
  assign ssr     = (pss_r + 64'sd536870912) >>> 30;
  assign ccr     = (pcc_r + 64'sd536870912) >>> 30;
  assign mr      = (m_r + 64'sd536870912) >>> 30;
  assign t_sum   = 35'(a3_r) + 35'($signed(mr[31:0]));
  assign tt_full = t_r * t_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sn_r[j] <= rot_c[CORDIC_STEPS][j].neg ? 32'(-rot_c[CORDIC_STEPS][j].y)
                                              : 32'(rot_c[CORDIC_STEPS][j].y);
        cs_r[j] <= rot_c[CORDIC_STEPS][j].neg ? 32'(-rot_c[CORDIC_STEPS][j].x)
                                              : 32'(rot_c[CORDIC_STEPS][j].x);
      end
      pss_r <= 64'(sn_r[0]) * 64'(sn_r[1]);
      pcc_r <= 64'(cs_r[0]) * 64'(cs_r[1]);
      cd1_r <= cs_r[2];
      a2_r  <= ssr[31:0];
      cc2_r <= ccr[31:0];
      cd2_r <= cd1_r;
      m_r   <= 64'(cc2_r) * 64'(cd2_r);
      a3_r  <= a2_r;
      if (t_sum > ONE_Q30) begin
        t_r <= ONE_Q30[31:0];
      end else if (t_sum < -ONE_Q30) begin
        t_r <= 32'(-ONE_Q30);
      end else begin
        t_r <= t_sum[31:0];
      end
      tt_r           <= tt_full[60:0];
      t_q_r          <= t_r;
      root_q_r.v     <= (61'd1 << 60) - tt_r;
      root_q_r.res   <= '0;
      root_q_r.t     <= t_q_r;
    end
  end

  assign root_c[0] = root_q_r;

  generate
    for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_root
      gcd_root_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .idx   (ROOT_W'(SQRT_STEPS - 1 - gi)),
        .d_in  (root_c[gi]),
        .d_out (root_c[gi+1])
      );
    end
  endgenerate

  // Arccosine as the angle of the vector (sqrt(1 - t^2), t) from pi/2.
  assign vec_c[0].x = $signed({3'b0, root_c[SQRT_STEPS].res[30:0]});
  assign vec_c[0].y = 34'(root_c[SQRT_STEPS].t);
  assign vec_c[0].z = '0;

  generate
    for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_vec
      gcd_vec_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .idx   (STEP_W'(gi)),
        .d_in  (vec_c[gi]),
        .d_out (vec_c[gi+1])
      );
    end
  endgenerate

  assign theta_s  = HALF_PI_Q30 - 35'(vec_c[CORDIC_STEPS].z);
  assign dist_sum = 55'(rprod_r) + 55'd536870912;

  always_ff @(posedge clk) begin
    if (adv) begin
      theta_r <= (theta_s < 0) ? 32'd0 : theta_s[31:0];
      rprod_r <= 54'(radius_r) * 54'(theta_r);
      if (dist_sum[54:30] > 25'(DIST_MAX)) begin
        dist_r <= DIST_MAX;
      end else begin
        dist_r <= dist_sum[53:30];
      end
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_distance = dist_r;

  `GCD_ASSERT_HOLD(a_stall_hold, !adv, vld_r, "pipeline moved while the output was stalled")
  `GCD_ASSERT(a_t_clamp, vld_r[VP4] |-> (t_r <= 32'sd1073741824 && t_r >= -32'sd1073741824),
              "cosine argument left the clamp range")
  `GCD_ASSERT(a_root_max, vld_r[VSQ] |-> (root_c[SQRT_STEPS].res <= 62'd1073741824),
              "square root exceeded one")
  `GCD_ASSERT(a_theta_max, vld_r[VF] |-> (theta_r <= 32'd3400000000),
              "central angle exceeded pi")

endmodule

[bench/tb_great_circle_distance_core.sv]
`timescale 1ns / 1ps

module tb_great_circle_distance_core import gcd_pkg::*;;

  typedef struct packed {
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
  } route_t;

  localparam int IDLE_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] in_start_latitude = '0;
  logic signed [24:0] in_start_longitude = '0;
  logic signed [23:0] in_end_latitude = '0;
  logic signed [24:0] in_end_longitude = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [23:0]        out_distance;
  logic               cfg_we = 1'b0;
  logic [21:0]        cfg_wdata = '0;

  route_t      pending_routes[$];
  logic [23:0] expected_distances[$];
  logic [21:0] model_radius;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count;
  int          quiet_cycles;

  longint atan_tab [0:29] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63,
    31, 15, 7, 3, 1};

  great_circle_distance_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_latitude (in_start_latitude),
    .in_start_longitude(in_start_longitude),
    .in_end_latitude   (in_end_latitude),
    .in_end_longitude  (in_end_longitude),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_distance      (out_distance),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Folds the angle into [-90, 90] degrees and runs the rotation CORDIC.
  function automatic void sine_cosine(input longint deg, output longint sn,
                                      output longint cs);
    longint r;
    longint x;
    longint y;
    longint z;
    longint dx;
    bit     flip;
    r = deg % 64'sd23592960;
    flip = 1'b0;
    if (r < 0) r += 64'sd23592960;
    if (r >= 64'sd11796480) r -= 64'sd23592960;
    if (r > 64'sd5898240) begin
      r -= 64'sd11796480;
      flip = 1'b1;
    end else if (r < -64'sd5898240) begin
      r += 64'sd11796480;
      flip = 1'b1;
    end
    z = (r * 64'sd18740330 + 64'sd32768) >>> 16;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      if (z >= 0) begin
        y += x >>> i;
        x -= dx;
        z -= (i < 30) ? atan_tab[i] : 0;
      end else begin
        y -= x >>> i;
        x += dx;
        z += (i < 30) ? atan_tab[i] : 0;
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [23:0] route_distance(input route_t q, input logic [21:0] radius);
    longint s1, c1, s2, c2, sd, cd, t, x, y, z, dx, theta;
    longint unsigned d;
    sine_cosine(longint'(q.lat_a), s1, c1);
    sine_cosine(longint'(q.lat_b), s2, c2);
    sine_cosine(longint'(q.lon_a) - longint'(q.lon_b), sd, cd);
    t = mul_q30(s1, s2) + mul_q30(mul_q30(c1, c2), cd);
    if (t > 64'sd1073741824) t = 64'sd1073741824;
    if (t < -64'sd1073741824) t = -64'sd1073741824;
    x = root_floor(longint'(64'sd1 <<< 60) - t * t);
    y = t;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      if (y > 0) begin
        y -= x >>> i;
        x += dx;
        z += (i < 30) ? atan_tab[i] : 0;
      end else begin
        y += x >>> i;
        x -= dx;
        z -= (i < 30) ? atan_tab[i] : 0;
      end
    end
    theta = 64'sd1686629713 - z;
    if (theta < 0) theta = 0;
    d = (longint'(radius) * theta + (64'sd1 <<< 29)) >> 30;
    if (d > 64'd16777215) d = 64'd16777215;
    return d[23:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Driver: the head of the queue is what sits on the input port.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_distances.push_back(route_distance(pending_routes[0], model_radius));
        void'(pending_routes.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_routes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid           <= 1'b1;
          in_start_latitude  <= pending_routes[0].lat_a;
          in_start_longitude <= pending_routes[0].lon_a;
          in_end_latitude    <= pending_routes[0].lat_b;
          in_end_longitude   <= pending_routes[0].lon_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (expected_distances.size() == 0) begin
          report_mismatch($sformatf("unexpected distance %0d", out_distance));
        end else begin
          if (out_distance !== expected_distances[0])
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      out_distance, expected_distances[0]));
          void'(expected_distances.pop_front());
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (pending_routes.size() == 0 && expected_distances.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired");
        $display("** great_circle_distance_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic route_t make_route(input longint la1, input longint lo1,
                                        input longint la2, input longint lo2);
    route_t q;
    q.lat_a = la1[23:0];
    q.lon_a = lo1[24:0];
    q.lat_b = la2[23:0];
    q.lon_b = lo2[24:0];
    return q;
  endfunction

  // Mostly legal coordinates; some raw bit patterns beyond the nominal range.
  function automatic route_t random_route();
    route_t q;
    if ($urandom_range(99) < 15) begin
      q = route_t'(98'({$urandom, $urandom, $urandom, $urandom}));
    end else begin
      q.lat_a = 24'($urandom_range(11796480)) - 24'sd5898240;
      q.lon_a = 25'($urandom_range(23592960)) - 25'sd11796480;
      q.lat_b = 24'($urandom_range(11796480)) - 24'sd5898240;
      q.lon_b = 25'($urandom_range(23592960)) - 25'sd11796480;
      // Near pairs exercise the cosine argument near one.
      if ($urandom_range(9) == 0) begin
        q.lat_b = q.lat_a + $signed(24'($urandom_range(64))) - 24'sd32;
        q.lon_b = q.lon_a;
      end
    end
    return q;
  endfunction

  task automatic drain_and_write(input logic [21:0] radius);
    wait (pending_routes.size() == 0 && expected_distances.size() == 0);
    repeat (150) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= radius;
    @(posedge clk);
    cfg_we       <= 1'b0;
    model_radius = radius;
  endtask

  initial begin
    logic [21:0] radii [4];
    model_radius   = RADIUS_RESET;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    radii = '{22'd1630979, 22'd4194303, 22'd0, 22'($urandom_range(4194303))};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes, poles, identical and antipodal points.
    pending_routes.push_back(make_route(0, 0, 0, 0));
    pending_routes.push_back(make_route(5898240, 0, -5898240, 0));
    pending_routes.push_back(make_route(0, 0, 0, 11796480));
    pending_routes.push_back(make_route(0, -11796480, 0, 11796480));
    pending_routes.push_back(make_route(-5898240, -11796480, 5898240, 11796480));
    pending_routes.push_back(make_route(3000000, 1234567, 3000000, 1234567));
    pending_routes.push_back(make_route(3000000, 1234567, -3000000, 1234567 - 11796480));
    pending_routes.push_back(make_route(8388607, 16777215, -8388608, -16777216));
    pending_routes.push_back(make_route(-8388608, -16777216, 8388607, 16777215));
    pending_routes.push_back(make_route(5898240, 100, 5898240, 9000000));
    pending_routes.push_back(make_route(1, 0, 0, 1));
    pending_routes.push_back(make_route(7000000, 0, -7000000, 0));
    pending_routes.push_back(make_route(0, 0, 1, 0));

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) drain_and_write(radii[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < 112; n++) pending_routes.push_back(random_route());
    end

    wait (pending_routes.size() == 0 && expected_distances.size() == 0);
    repeat (150) @(posedge clk);
    if (error_count == 0) begin
      $display("** great_circle_distance_core: PASSED **");
    end else begin
      $display("** great_circle_distance_core: FAILED **");
    end
    $finish;
  end

endmodule
